// ----- hw/rtl/fsa_pkg.sv -----
// Shared types and constants for the free slot allocator.
// Used by every module under hw/rtl; depends on nothing else.

package fsa_pkg;

  // Width of the slot count register, of the list head and of the stored links.
  localparam int unsigned CNT_W = 11;
  // Width of a slot index on the ports.
  localparam int unsigned IDX_W = 10;
  // Slot count after reset.
  localparam int unsigned CNT_RESET = 1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } fsa_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE_ERR = 2'd2
  } fsa_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } fsa_state_e;

  typedef struct packed {
    fsa_op_e            op;
    logic [IDX_W-1:0]   slot_index;
  } fsa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   granted_index;
    fsa_status_e        status;
  } fsa_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // a request is taken in this cycle
    logic pop_done;  // the link read for a list pop is available
  } fsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_pop;  // the offered request pops the free list
  } fsa_stat_t;

endpackage

// ----- hw/rtl/fsa_ctrl.sv -----
// Controller state machine of the free slot allocator.
// Depends on fsa_pkg for the state, command and status types.

module fsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fsa_pkg::fsa_stat_t  stat_i,
  output fsa_pkg::fsa_cmd_t   cmd_o,
  output logic                busy_o
);

  fsa_pkg::fsa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    busy_o          = 1'b0;
    unique case (state_q)
      fsa_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          // A list pop waits in S_POP for the registered link read.
          if (stat_i.list_pop) begin
            state_d = fsa_pkg::S_POP;
          end
        end
      end
      fsa_pkg::S_POP: begin
        busy_o         = 1'b1;
        cmd_o.pop_done = 1'b1;
        state_d        = fsa_pkg::S_IDLE;
      end
      default: begin
        state_d = fsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fsa_datapath.sv -----
// Datapath of the free slot allocator: pool registers, bump counter, list head,
// per-slot link memory and result register. Depends on fsa_pkg.

module fsa_datapath #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fsa_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  fsa_pkg::fsa_req_t                 req_i,
  input  fsa_pkg::fsa_cmd_t                 cmd_i,
  output fsa_pkg::fsa_stat_t                stat_o,
  output logic                              done_o,
  output fsa_pkg::fsa_rsp_t                 rsp_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  // The count register cannot exceed its own range, so clamping above that is moot.
  localparam int unsigned CNT_MAX = (1 << fsa_pkg::CNT_W) - 1;
  localparam int unsigned CLAMP = (MAX_SLOTS > CNT_MAX) ? CNT_MAX : MAX_SLOTS;
  localparam int unsigned N_RST = (MAX_SLOTS < fsa_pkg::CNT_RESET) ?
                                  MAX_SLOTS : fsa_pkg::CNT_RESET;
  localparam logic [fsa_pkg::CNT_W-1:0] N_MAX   = fsa_pkg::CNT_W'(CLAMP);
  localparam logic [fsa_pkg::CNT_W-1:0] N_RESET = fsa_pkg::CNT_W'(N_RST);

  logic [fsa_pkg::CNT_W-1:0] pool_n_q, pool_n_d;
  logic [fsa_pkg::CNT_W-1:0] head_q, head_d;
  logic [fsa_pkg::CNT_W-1:0] bump_q, bump_d;
  logic                      bump_done_q, bump_done_d;
  logic                      done_q, done_d;
  fsa_pkg::fsa_rsp_t         rsp_q, rsp_d;

  logic [fsa_pkg::CNT_W-1:0] link_mem [MAX_SLOTS];
  logic [fsa_pkg::CNT_W-1:0] link_rdata_q;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;

  logic [fsa_pkg::CNT_W-1:0] n_cfg;
  logic                      bump_avail, head_valid, idx_ok, is_alloc;

  assign n_cfg      = (cfg_wdata_i > N_MAX) ? N_MAX : cfg_wdata_i;
  assign bump_avail = !bump_done_q && (bump_q < pool_n_q);
  assign head_valid = head_q < pool_n_q;
  assign idx_ok     = {1'b0, req_i.slot_index} < pool_n_q;
  assign is_alloc   = req_i.op == fsa_pkg::OP_ALLOC;

  assign stat_o.list_pop = is_alloc && !bump_avail && head_valid;

  // Index and head values used as addresses are below the pool size, so they fit.
  assign mem_waddr = AW'(req_i.slot_index);
  assign mem_raddr = AW'(head_q);
  assign mem_we    = cmd_i.accept && !is_alloc && idx_ok;
  assign mem_re    = cmd_i.accept && stat_o.list_pop;

  always_comb begin
    pool_n_d    = pool_n_q;
    head_d      = head_q;
    bump_d      = bump_q;
    bump_done_d = bump_done_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;

    if (cmd_i.accept) begin
      if (is_alloc) begin
        if (bump_avail) begin
          bump_d              = bump_q + fsa_pkg::CNT_W'(1);
          done_d              = 1'b1;
          rsp_d.granted_index = bump_q[fsa_pkg::IDX_W-1:0];
          rsp_d.status        = fsa_pkg::ST_OK;
        end else begin
          // The bump phase ends on the first allocate that finds it used up.
          bump_done_d = 1'b1;
          if (!head_valid) begin
            done_d              = 1'b1;
            rsp_d.granted_index = '0;
            rsp_d.status        = fsa_pkg::ST_EXHAUSTED;
          end
        end
      end else begin
        done_d = 1'b1;
        rsp_d.granted_index = '0;
        if (idx_ok) begin
          head_d       = {1'b0, req_i.slot_index};
          rsp_d.status = fsa_pkg::ST_OK;
        end else begin
          rsp_d.status = fsa_pkg::ST_RANGE_ERR;
        end
      end
    end

    if (cmd_i.pop_done) begin
      done_d              = 1'b1;
      rsp_d.granted_index = head_q[fsa_pkg::IDX_W-1:0];
      rsp_d.status        = fsa_pkg::ST_OK;
      head_d              = link_rdata_q;
    end

    // A new slot count restarts the pool; stored links are kept.
    if (cfg_we_i) begin
      pool_n_d    = n_cfg;
      head_d      = n_cfg;
      bump_d      = '0;
      bump_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_n_q    <= N_RESET;
      head_q      <= N_RESET;
      bump_q      <= '0;
      bump_done_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      pool_n_q    <= pool_n_d;
      head_q      <= head_d;
      bump_q      <= bump_d;
      bump_done_q <= bump_done_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      link_rdata_q <= link_mem[mem_raddr];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- hw/rtl/free_slot_allocator_top.sv -----
// Channel    Handshake                       Payload
// request    start_i, accepted when !busy_o  req_i (fsa_pkg::fsa_req_t)
// result     done_o, one-cycle strobe        rsp_o (fsa_pkg::fsa_rsp_t)
// config     cfg_we_i, no wait               cfg_wdata_i (slot count)
//
// Frees and allocates that do not pop the free list are answered from the result register
// in the cycle after the accepting one, and a new request can be taken in that cycle.
// Allocates served from the free list wait in S_POP for the registered read of the
// link memory; busy_o is high while the controller is in S_POP.
// Reset clears the control registers only; the link memory needs no clearing pass.
// The receiver cannot stall, so every result is delivered on its strobe cycle.
//
// Top level of the free slot allocator. Depends on fsa_pkg, fsa_ctrl, fsa_datapath.

module free_slot_allocator_top #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fsa_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        start_i,
  input  fsa_pkg::fsa_req_t           req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output fsa_pkg::fsa_rsp_t           rsp_o
);

  fsa_pkg::fsa_cmd_t  cmd;
  fsa_pkg::fsa_stat_t stat;

  fsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  fsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- hw/rtl/fsa_checker.sv -----
// Port-level checks for the free slot allocator, bound to the top level.
// Depends on fsa_pkg for the request and result types.

module fsa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input fsa_pkg::fsa_req_t  req_i,
  input logic               done_o,
  input fsa_pkg::fsa_rsp_t  rsp_o
);

  // A busy cycle is always the last cycle of a list pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
  else $error("busy did not end with a result");

  // Every accepted transaction either answers next cycle or goes busy, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o != busy_o))
  else $error("accepted transaction lost or doubled");

  // A free answers at once and never reports the pool exhausted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.op == fsa_pkg::OP_FREE) |=>
      (done_o && rsp_o.status != fsa_pkg::ST_EXHAUSTED))
  else $error("bad result for a free transaction");

  // Failed transactions hand out no slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != fsa_pkg::ST_OK) |-> (rsp_o.granted_index == '0))
  else $error("slot index reported on a failed transaction");

endmodule

bind free_slot_allocator_top fsa_checker u_fsa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

// ----- tb/free_slot_allocator_top_tb.sv -----
// Self-checking testbench for free_slot_allocator_top: directed table, then random phases.
// Expected results come from a behavioral copy of the pool kept in this file, or from the table for pinned rows.
// Depends on fsa_pkg and the free_slot_allocator_top RTL.

module free_slot_allocator_top_tb;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned LIMIT = 200000;
  localparam int unsigned N_DIR = 26;
  localparam int unsigned N_PHASE = 10;
  localparam int unsigned PHASE_LEN = 60;

  typedef struct packed {
    logic                      is_cfg;
    logic [fsa_pkg::CNT_W-1:0] cnt;
    fsa_pkg::fsa_req_t         q;
    logic                      pinned;
    fsa_pkg::fsa_rsp_t         want;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [fsa_pkg::CNT_W-1:0] cfg_wdata_i = '0;
  logic                      start_i = 1'b0;
  fsa_pkg::fsa_req_t         req_i = '{fsa_pkg::OP_ALLOC, '0};
  logic                      busy_o;
  logic                      done_o;
  fsa_pkg::fsa_rsp_t         rsp_o;

  // Behavioral copy of the pool.
  logic [fsa_pkg::CNT_W-1:0] link_mem [SLOTS];
  logic [fsa_pkg::CNT_W-1:0] pool_cnt;
  logic [fsa_pkg::CNT_W-1:0] list_head;
  logic [fsa_pkg::CNT_W-1:0] bump_cnt;
  logic                      bump_fin;

  fsa_pkg::fsa_rsp_t         grant_q [$];
  logic [fsa_pkg::IDX_W-1:0] held_q [$];
  dir_row_t                  dir_tab [N_DIR];
  logic                      pinned_on = 1'b0;
  fsa_pkg::fsa_rsp_t         pinned_rsp;
  int                        fail_cnt = 0;
  int                        cyc_cnt = 0;
  int                        idle_pct = 0;
  int                        free_bias = 50;

  free_slot_allocator_top #(.MAX_SLOTS(SLOTS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void pool_reload(logic [fsa_pkg::CNT_W-1:0] v);
    pool_cnt  = (v > SLOTS) ? fsa_pkg::CNT_W'(SLOTS) : v;
    list_head = pool_cnt;
    bump_cnt  = '0;
    bump_fin  = 1'b0;
  endfunction

  function automatic fsa_pkg::fsa_rsp_t pool_serve(fsa_pkg::fsa_req_t q);
    fsa_pkg::fsa_rsp_t r;
    logic              served;
    r.granted_index = '0;
    r.status        = fsa_pkg::ST_OK;
    served          = 1'b0;
    if (q.op == fsa_pkg::OP_ALLOC) begin
      if (!bump_fin) begin
        if (bump_cnt < pool_cnt) begin
          r.granted_index = bump_cnt[fsa_pkg::IDX_W-1:0];
          bump_cnt        = bump_cnt + 1'b1;
          served          = 1'b1;
        end else begin
          bump_fin = 1'b1;
        end
      end
      if (!served) begin
        // A head at or above the pool size is the empty-list sentinel.
        if (list_head >= pool_cnt) begin
          r.status = fsa_pkg::ST_EXHAUSTED;
        end else begin
          r.granted_index = list_head[fsa_pkg::IDX_W-1:0];
          list_head       = link_mem[list_head[fsa_pkg::IDX_W-1:0]];
        end
      end
    end else if ({1'b0, q.slot_index} >= pool_cnt) begin
      r.status = fsa_pkg::ST_RANGE_ERR;
    end else begin
      link_mem[q.slot_index] = list_head;
      list_head              = {1'b0, q.slot_index};
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    fsa_pkg::fsa_rsp_t pred;
    fsa_pkg::fsa_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: granted %0d status %0d",
                     rsp_o.granted_index, rsp_o.status);
        end else begin
          want = grant_q.pop_front();
          if (rsp_o.granted_index !== want.granted_index || rsp_o.status !== want.status) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: granted %0d status %0d, expected granted %0d status %0d",
                       rsp_o.granted_index, rsp_o.status, want.granted_index, want.status);
          end
        end
      end
      if (cfg_we_i)
        pool_reload(cfg_wdata_i);
      if (start_i && !busy_o) begin
        pred = pool_serve(req_i);
        if (req_i.op == fsa_pkg::OP_ALLOC && pred.status == fsa_pkg::ST_OK)
          held_q.push_back(pred.granted_index);
        grant_q.push_back(pinned_on ? pinned_rsp : pred);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT) begin
      $display("free_slot_allocator_top_tb: FAIL");
      $finish;
    end
  end

  // All tasks below are entered and left at a falling clock edge.
  task automatic issue(fsa_pkg::fsa_req_t q);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= q;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (grant_q.size() != 0);
  endtask

  task automatic write_count(logic [fsa_pkg::CNT_W-1:0] v);
    drain();
    // Let the bench sit idle between the last result and the write.
    repeat (3) @(negedge clk_i);
    held_q.delete();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic pick_req(output fsa_pkg::fsa_req_t q);
    int k;
    int j;
    q.op         = fsa_pkg::OP_ALLOC;
    q.slot_index = fsa_pkg::IDX_W'($urandom_range(SLOTS - 1));
    k            = $urandom_range(99);
    if (k < 15) begin
      q.op = fsa_pkg::OP_FREE;
    end else if (k < 30 && pool_cnt != 0) begin
      q.op         = fsa_pkg::OP_FREE;
      q.slot_index = fsa_pkg::IDX_W'($urandom_range(pool_cnt - 1));
    end else if (held_q.size() != 0 && $urandom_range(99) < free_bias) begin
      // Well-formed traffic returns a slot that was granted since the last count write.
      j            = $urandom_range(held_q.size() - 1);
      q.op         = fsa_pkg::OP_FREE;
      q.slot_index = held_q[j];
      held_q.delete(j);
    end
  endtask

  initial begin : stim
    fsa_pkg::fsa_req_t         q;
    logic [fsa_pkg::CNT_W-1:0] cnt;
    logic [fsa_pkg::CNT_W-1:0] phase_cnt [8];
    phase_cnt = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd1024, 11'd0, 11'd2047};
    dir_tab = '{
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd1023}, 1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd1023}, 1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd1, fsa_pkg::ST_OK}},
      '{1'b1, 11'd2,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b0, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd2},    1'b1,
        '{10'd0, fsa_pkg::ST_RANGE_ERR}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd1023}, 1'b1,
        '{10'd0, fsa_pkg::ST_RANGE_ERR}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd555},  1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd1, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1,
        '{10'd0, fsa_pkg::ST_EXHAUSTED}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd1},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd1},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd1, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd1, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd0},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b1, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b0, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1,
        '{10'd0, fsa_pkg::ST_EXHAUSTED}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd0},    1'b1,
        '{10'd0, fsa_pkg::ST_RANGE_ERR}},
      '{1'b1, 11'd2047, '{fsa_pkg::OP_ALLOC, 10'd0},    1'b0, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd1023}, 1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b1, 11'd1,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b0, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b1,
        '{10'd0, fsa_pkg::ST_EXHAUSTED}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_FREE,  10'd0},    1'b1, '{10'd0, fsa_pkg::ST_OK}},
      '{1'b0, 11'd0,    '{fsa_pkg::OP_ALLOC, 10'd0},    1'b0, '{10'd0, fsa_pkg::ST_OK}}
    };
    pool_reload(fsa_pkg::CNT_W'(fsa_pkg::CNT_RESET));
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].is_cfg) begin
        write_count(dir_tab[i].cnt);
      end else begin
        pinned_on  = dir_tab[i].pinned;
        pinned_rsp = dir_tab[i].want;
        issue(dir_tab[i].q);
        pinned_on  = 1'b0;
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      if (p < 8)
        cnt = phase_cnt[p];
      else if (p == 8)
        cnt = fsa_pkg::CNT_W'($urandom_range(1, 64));
      else
        cnt = fsa_pkg::CNT_W'($urandom_range(1, 2047));
      write_count(cnt);
      idle_pct  = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 46 : 32);
      free_bias = $urandom_range(30, 60);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(49) == 0)
          drain();
        pick_req(q);
        issue(q);
      end
    end

    drain();
    repeat (6) @(negedge clk_i);
    if (fail_cnt == 0 && grant_q.size() == 0) begin
      $display("free_slot_allocator_top_tb: PASS");
    end else begin
      $display("free_slot_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
